// ===== hw/rtl/itoa_pkg.sv =====
package itoa_pkg;

    // Width of the converted value and the sizes that follow from it.
    localparam int VALUE_BITS = 16;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int DEPTH_W    = $clog2(VALUE_BITS + 1);
    localparam int VALUE_BYTES_W = ((VALUE_BITS + 7) / 8) * 8;

    // Radix register and digit widths.
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

    // ASCII codes used in the text.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } seq_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_W-1:0]    divisor;
    } div_req_t;

    // Result from the shared divider.
    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [RADIX_W-1:0]    remainder;
    } div_rsp_t;

    // Map one digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE) begin
            c = CHAR_LOW_A + CHAR_W'(d - DIGIT_TEN);
        end else begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_radix.sv =====
// Channel   Direction  Payload
// s_*       in         s_tdata[15:0] value (signed in radix ten, else unsigned)
// m_*       out        m_tdata[7:0] character, m_tlast last
// cfg_*     in         cfg_data[5:0] radix
//
// Each digit is divided out in the shared bit-serial divider, and the
// characters are emitted once all digits of the item are on the stack.
// Reset sets the radix to ten and leaves the block idle.
// The input is not ready while an item is being converted or emitted; a
// stalled m_tready holds the current character and pauses the emit phase.
module integer_to_ascii_radix
    import itoa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_BITS-1:0] s_tdata,   // [15:0] value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHAR_W-1:0]     m_tdata,   // [7:0] character
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RADIX_W-1:0]    cfg_data   // [5:0] radix
);

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_eff;
    div_req_t           req;
    div_rsp_t           rsp;

    assign cfg_ready = 1'b1;

    // Radix register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid) begin
            radix_reg <= cfg_data;
        end
    end

    // Out-of-range radix values are clamped to two or thirty-six.
    always_comb
    begin
        if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    itoa_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix     (radix_eff),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .req       (req),
        .rsp       (rsp)
    );

    itoa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== hw/rtl/itoa_div.sv =====
module itoa_div
    import itoa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    div_reg, div_next;
    logic [RADIX_W:0]      trial;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = RADIX_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[RADIX_W-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hw/rtl/itoa_seq.sv =====
module itoa_seq
    import itoa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [RADIX_W-1:0]    radix,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAR_W-1:0]     out_char,
    output logic                  out_last,
    output div_req_t              req,
    input  div_rsp_t              rsp
);

    seq_state_t            state_reg, state_next;
    logic                  neg_reg, neg_next;
    logic [RADIX_W-1:0]    base_reg, base_next;
    logic [DEPTH_W-1:0]    count_reg, count_next;
    logic [RADIX_W-1:0]    stack_reg [VALUE_BITS];
    logic                  push;
    logic                  ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  accept;
    logic                  load_ok;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [DEPTH_W-1:0]    top_idx;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_ok  = !ovalid_reg || out_ready;
    assign top_idx  = count_reg - 1'b1;

    // Decimal negatives convert their magnitude; other radices read unsigned.
    assign in_neg = (radix == RADIX_DEC) && in_value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~in_value + 1'b1) : in_value;

    // Sequencer: divide out digits onto the stack, then emit any sign and pop them out.
    always_comb
    begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        base_next    = base_reg;
        count_next   = count_reg;
        push         = 1'b0;
        ovalid_next  = ovalid_reg && !out_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        req.start    = 1'b0;
        req.dividend = rsp.quotient;
        req.divisor  = base_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    req.start    = 1'b1;
                    req.dividend = in_mag;
                    req.divisor  = radix;
                    base_next    = radix;
                    neg_next     = in_neg;
                    count_next   = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rsp.done) begin
                    push       = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (rsp.quotient == '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        req.start = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_ok) begin
                    ovalid_next = 1'b1;
                    if (neg_reg) begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end else begin
                        char_next  = digit_char(stack_reg[top_idx[CNT_W-1:0]]);
                        last_next  = (count_reg == DEPTH_W'(1));
                        count_next = count_reg - 1'b1;
                        if (count_reg == DEPTH_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            neg_reg    <= 1'b0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            neg_reg    <= neg_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Digit stack and output payload.
    always_ff @(posedge clk)
    begin
        if (push) begin
            stack_reg[count_reg[CNT_W-1:0]] <= rsp.remainder;
        end
        base_reg <= base_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = ovalid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// ===== bench/integer_to_ascii_radix_tb.sv =====
module integer_to_ascii_radix_tb;

    import itoa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 600;

    // One expected character of the text.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_BITS-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CHAR_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [RADIX_W-1:0]    cfg_data = '0;

    logic [VALUE_BITS-1:0] pending_values[$];
    text_char_t            expected_text[$];
    logic [RADIX_W-1:0]    radix_reg = RADIX_RESET;
    int                    send_gap_max = 15;
    int                    recv_gap_max = 15;
    int                    send_wait = 0;
    int                    recv_wait = 0;
    int                    hold_cycles = 0;
    int                    fail_count = 0;
    int                    cycle_count = 0;

    integer_to_ascii_radix dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // Work out the text of one value in the current radix and queue it.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        int unsigned           base;
        int unsigned           mag;
        int unsigned           d;
        int                    m;
        logic [VALUE_BITS-1:0] neg_value;
        logic [CHAR_W-1:0]     rev[0:VALUE_BITS+1];
        text_char_t            item;
        base = radix_reg;
        if (radix_reg < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        mag = value;
        m = 0;
        if (base == RADIX_DEC && value[VALUE_BITS-1]) begin
            neg_value = -value;
            mag = neg_value;
            item.ch = CHAR_MINUS;
            item.last = 1'b0;
            expected_text.push_back(item);
        end
        if (mag == 0) begin
            item.ch = CHAR_ZERO;
            item.last = 1'b1;
            expected_text.push_back(item);
        end else begin
            // Digits come out least significant first.
            while (mag != 0) begin
                d = mag % base;
                mag = mag / base;
                if (d > 9) begin
                    rev[m] = CHAR_LOW_A + CHAR_W'(d - 10);
                end else begin
                    rev[m] = CHAR_ZERO + CHAR_W'(d);
                end
                m++;
            end
            while (m > 0) begin
                m--;
                item.ch = rev[m];
                item.last = (m == 0);
                expected_text.push_back(item);
            end
        end
    endfunction

    // Random value: full range, small, small negative or an extreme.
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 3))
            0: v = VALUE_BITS'($urandom);
            1: v = VALUE_BITS'($urandom_range(0, 40));
            2: v = -VALUE_BITS'($urandom_range(1, 40));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = '1;
                    2: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
                    default: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
                endcase
            end
        endcase
        return v;
    endfunction

    // Write the radix register and track it for prediction.
    task automatic set_radix(input logic [RADIX_W-1:0] r);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        radix_reg = r;
    endtask

    // Wait until every queued item has been sent and its text has arrived.
    task automatic drain();
        while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Driver: offers queued items with a random gap after each one.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                predict_text(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_values.size() > 0) begin
                    s_tdata <= pending_values.pop_front();
                    s_tvalid <= 1'b1;
                    send_wait = $urandom_range(0, send_gap_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each character against the oldest expectation.
    always @(posedge clk) begin
        text_char_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch) begin
                        $display("%0t: character mismatch, expected %h, actual %h",
                                 $time, want.ch, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                end
                recv_wait = $urandom_range(0, recv_gap_max);
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [RADIX_W-1:0] phase_radix[10];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset radix is ten: signs, zero and the most negative value.
        pending_values = '{16'd0, 16'd1, 16'hffff, 16'h7fff, 16'h8000,
                           16'd9, 16'd10, -16'sd10, 16'd12345, -16'sd12345};
        drain();

        // Binary gives the longest text.
        set_radix(RADIX_MIN);
        pending_values = '{16'd0, 16'hffff, 16'h7fff, 16'h8000, 16'd1};
        drain();

        // Highest radix reaches the last letter.
        set_radix(RADIX_MAX);
        pending_values = '{16'd35, 16'd36, 16'hffff, 16'h8000};
        drain();

        // Radix below two is treated as binary.
        set_radix(6'd0);
        pending_values = '{16'd5};
        drain();
        set_radix(6'd1);
        pending_values = '{16'd6};
        drain();

        // Radix above thirty-six is treated as the highest radix.
        set_radix(6'd37);
        pending_values = '{16'd35, 16'd36};
        drain();
        set_radix(6'd63);
        pending_values = '{16'hffff};
        drain();

        // Random phases with a range of radices and idling patterns.
        phase_radix = '{6'd10, 6'd2, 6'd36, 6'd63, 6'd7, 6'd10, 6'd16, 6'd1,
                        RADIX_W'($urandom_range(0, 63)), RADIX_W'($urandom_range(0, 63))};
        for (int p = 0; p < 10; p++) begin
            set_radix(phase_radix[p]);
            if (p % 4 == 1) begin
                send_gap_max = 0;
                recv_gap_max = 0;
            end else begin
                send_gap_max = 15;
                recv_gap_max = 15;
            end
            // The receiver stalls for a long stretch while the sender keeps going.
            if (p == 5) begin
                send_gap_max = 0;
                hold_cycles = HOLD_OFF_CYCLES;
            end
            for (int i = 0; i < 13; i++) begin
                pending_values.push_back(random_value());
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_div.sv
hw/rtl/itoa_seq.sv
hw/rtl/integer_to_ascii_radix.sv
bench/integer_to_ascii_radix_tb.sv
